>>> rtl/core/rarh_pkg.sv
`timescale 1ns / 1ps

package rarh_pkg;

	localparam int RATE_BITS = 48;
	localparam int TGT_BITS  = RATE_BITS + 1;
	localparam int EXP_W     = 6;
	localparam int CNT_W     = 4;
	localparam int SHIFT_W   = 4;

	localparam logic [EXP_W-1:0] MIN_SCALE_RST  = EXP_W'(15);
	localparam logic [SHIFT_W-1:0] HEADROOM_RST = SHIFT_W'(2);
	localparam logic [SHIFT_W-1:0] LOW_SHIFT_RST = SHIFT_W'(2);
	localparam logic [CNT_W-1:0] SHRINK_RST     = CNT_W'(10);

	localparam logic [EXP_W-1:0] MB_EXP = EXP_W'(20);
	localparam logic [EXP_W-1:0] GB_EXP = EXP_W'(30);

	localparam logic [1:0] UNIT_KB = 2'd0;
	localparam logic [1:0] UNIT_MB = 2'd1;
	localparam logic [1:0] UNIT_GB = 2'd2;

	typedef enum logic [1:0] {
		REG_MIN_SCALE = 2'd0,
		REG_HEADROOM  = 2'd1,
		REG_LOW_SHIFT = 2'd2,
		REG_SHRINK    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [RATE_BITS-1:0] rx_rate;
		logic [RATE_BITS-1:0] tx_rate;
	} in_item_t;

	typedef struct packed {
		logic [EXP_W-1:0] scale_log2;
		logic [1:0]       unit_code;
		logic             scale_changed;
	} out_item_t;

	// what stage 1 hands to the scale decision
	typedef struct packed {
		logic [EXP_W-1:0]    peak_len;  // bit length of peak
		logic [TGT_BITS-1:0] tgt_m1;    // target - 1, zero when peak is zero
	} s1_item_t;

	typedef struct packed {
		logic [EXP_W-1:0]   min_scale;
		logic [SHIFT_W-1:0] low_shift;
		logic [CNT_W-1:0]   shrink;
	} ctl_cfg_t;

	// bit length (index of leading one plus one), zero for zero
	function automatic logic [EXP_W-1:0] bit_len(input logic [TGT_BITS-1:0] v);
		logic [EXP_W-1:0] len;
		len = '0;
		for (int i = 0; i < TGT_BITS; i++) begin
			if (v[i]) len = EXP_W'(i + 1);
		end
		return len;
	endfunction

endpackage

>>> rtl/core/rate_auto_range_hysteresis_unit.sv
`timescale 1ns / 1ps

// Auto-ranging full scale for a pair of traffic rates, with hysteresis.
// Input channel: in_valid / in_stall / in_data (rx_rate, tx_rate). A request
//   is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall / out_data (scale_log2, unit_code,
//   scale_changed), one result per request, in order.
// Config channel: cfg_valid / cfg_ready / cfg_index / cfg_data. cfg_ready is
//   always high; write only while no request is in flight.
// The request passes the stage-1 register, then the result register, before
//   out_valid rises. Throughput: one request per cycle while out_stall does
//   not hold the result; the scale state is updated in the same cycle a
//   request leaves stage 1, so the next request sees it right away.
// Stage 1 forms peak, its bit length and target - 1; stage 2 does the
//   leading-one detect on target - 1 and the grow/shrink decision.
// Stall: when out_stall holds a pending result, stage 1 keeps its request and
//   in_stall rises only once stage 1 is also full; nothing is dropped.
// Reset: config registers to defaults (min scale 2^15, headroom >>2, low
//   threshold >>2, 10 samples to shrink), scale 2^15, count zero, pipe empty.
module rate_auto_range_hysteresis_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rarh_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output rarh_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [5:0]           cfg_data
);

	// config registers
	logic [rarh_pkg::EXP_W-1:0]   min_scale_q;
	logic [rarh_pkg::SHIFT_W-1:0] headroom_q;
	logic [rarh_pkg::SHIFT_W-1:0] low_shift_q;
	logic [rarh_pkg::CNT_W-1:0]   shrink_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_scale_q <= rarh_pkg::MIN_SCALE_RST;
			headroom_q  <= rarh_pkg::HEADROOM_RST;
			low_shift_q <= rarh_pkg::LOW_SHIFT_RST;
			shrink_q    <= rarh_pkg::SHRINK_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (rarh_pkg::cfg_reg_t'(cfg_index))
				rarh_pkg::REG_MIN_SCALE: min_scale_q <= cfg_data;
				rarh_pkg::REG_HEADROOM:  headroom_q  <= cfg_data[3:0];
				rarh_pkg::REG_LOW_SHIFT: low_shift_q <= cfg_data[3:0];
				rarh_pkg::REG_SHRINK:    shrink_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on when the result register is free or draining
	logic s1_valid_q;
	logic out_valid_q;
	logic advance;
	logic in_accept;

	assign advance   = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall  = s1_valid_q && !advance;
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept)
				s1_valid_q <= 1'b1;
			else if (advance)
				s1_valid_q <= 1'b0;

			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// stage 1: peak, headroom target
	logic [rarh_pkg::RATE_BITS-1:0] peak;
	logic [rarh_pkg::TGT_BITS-1:0]  peak_x;
	logic [rarh_pkg::TGT_BITS-1:0]  target;
	rarh_pkg::s1_item_t             s1_d;
	rarh_pkg::s1_item_t             item_s1;

	assign peak   = (in_data.rx_rate > in_data.tx_rate) ? in_data.rx_rate : in_data.tx_rate;
	assign peak_x = {1'b0, peak};
	assign target = peak_x + (peak_x >> headroom_q);

	always_comb begin
		s1_d.peak_len = rarh_pkg::bit_len(peak_x);
		// zero peak gives target zero; keep it at zero so the exponent is minimal
		s1_d.tgt_m1   = (peak == '0) ? '0 : target - rarh_pkg::TGT_BITS'(1);
	end

	always_ff @(posedge clk) begin
		if (in_accept)
			item_s1 <= s1_d;
	end

	// stage 2: scale decision and state
	rarh_pkg::ctl_cfg_t  ctl_cfg;
	rarh_pkg::out_item_t result;

	always_comb begin
		ctl_cfg.min_scale = min_scale_q;
		ctl_cfg.low_shift = low_shift_q;
		ctl_cfg.shrink    = shrink_q;
	end

	rarh_scale_ctl u_scale_ctl (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.s1_item (item_s1),
		.cfg     (ctl_cfg),
		.result  (result)
	);

	always_ff @(posedge clk) begin
		if (advance)
			out_data <= result;
	end

endmodule

>>> rtl/core/rarh_scale_ctl.sv
`timescale 1ns / 1ps

module rarh_scale_ctl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  rarh_pkg::s1_item_t   s1_item,
	input  rarh_pkg::ctl_cfg_t   cfg,
	output rarh_pkg::out_item_t  result
);

	logic [rarh_pkg::EXP_W-1:0] cur_q;
	logic [rarh_pkg::CNT_W-1:0] cnt_q;

	logic [rarh_pkg::EXP_W-1:0] tgt_exp;
	logic [rarh_pkg::EXP_W-1:0] want;
	logic                       low;
	logic [rarh_pkg::CNT_W-1:0] cnt_inc;
	logic [rarh_pkg::EXP_W-1:0] cur_d;
	logic [rarh_pkg::CNT_W-1:0] cnt_d;
	logic                       changed;

	// ceil(log2(target)) = bit length of (target - 1)
	assign tgt_exp = rarh_pkg::bit_len(s1_item.tgt_m1);
	assign want    = (tgt_exp > cfg.min_scale) ? tgt_exp : cfg.min_scale;
	// peak < 2^(cur - shift)  <=>  len(peak) + shift <= cur
	assign low = ({1'b0, s1_item.peak_len} + {3'b000, cfg.low_shift})
		<= {1'b0, cur_q};
	assign cnt_inc = cnt_q + rarh_pkg::CNT_W'(1);

	always_comb begin
		cur_d   = cur_q;
		cnt_d   = '0;
		changed = 1'b0;
		if (want > cur_q) begin
			cur_d   = want;
			changed = 1'b1;
		end else if (want < cur_q && low) begin
			if (cnt_inc >= cfg.shrink) begin
				cur_d   = want;
				changed = 1'b1;
			end else begin
				cnt_d = cnt_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= rarh_pkg::MIN_SCALE_RST;
			cnt_q <= '0;
		end else if (advance) begin
			cur_q <= cur_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		result.scale_log2    = cur_d;
		result.scale_changed = changed;
		if (cur_d >= rarh_pkg::GB_EXP)
			result.unit_code = rarh_pkg::UNIT_GB;
		else if (cur_d >= rarh_pkg::MB_EXP)
			result.unit_code = rarh_pkg::UNIT_MB;
		else
			result.unit_code = rarh_pkg::UNIT_KB;
	end

endmodule

>>> verif/tb_rate_auto_range_hysteresis_unit.sv
`timescale 1ns / 1ps

module tb_rate_auto_range_hysteresis_unit;

	localparam logic [rarh_pkg::RATE_BITS-1:0] RATE_MAX = '1;
	// full 48-bit rate plus headroom
	localparam logic [rarh_pkg::EXP_W-1:0]     EXP_TOP  = rarh_pkg::EXP_W'(49);
	localparam int                             PHASES   = 12;
	localparam int                             PHASE_LEN = 85;
	localparam int                             LONG_HOLD = 300;

	typedef struct {
		rarh_pkg::in_item_t  smp;
		bit                  pinned;   // res holds a hand-written answer
		rarh_pkg::out_item_t res;
	} dir_row_t;

	typedef struct {
		logic [5:0] min_v;
		logic [5:0] hr_v;
		logic [5:0] low_v;
		logic [5:0] shr_v;
	} reg_set_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	rarh_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_stall;
	rarh_pkg::out_item_t out_data;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [1:0]          cfg_index;
	logic [5:0]          cfg_data;

	// model copy of the register file
	logic [rarh_pkg::EXP_W-1:0]   min_exp    = rarh_pkg::MIN_SCALE_RST;
	logic [rarh_pkg::SHIFT_W-1:0] shift_hr   = rarh_pkg::HEADROOM_RST;
	logic [rarh_pkg::SHIFT_W-1:0] low_shift  = rarh_pkg::LOW_SHIFT_RST;
	logic [rarh_pkg::CNT_W-1:0]   shrink_len = rarh_pkg::SHRINK_RST;
	// model copy of the range state
	logic [rarh_pkg::EXP_W-1:0]   scale_now  = rarh_pkg::MIN_SCALE_RST;
	logic [rarh_pkg::CNT_W-1:0]   low_run    = '0;

	rarh_pkg::out_item_t pending_ranges[$];
	int                  errors = 0;
	int                  send_idle_pct = 0;
	int                  stall_pct = 0;
	int                  hold_left = 0;

	// Directed rows. Pinned rows run on reset config: zero, full-scale grow, a
	// busy sample that is not low, then ten idle samples that shrink on the tenth.
	dir_row_t dir_rows [21] = '{
		'{'{'0, '0}, 1'b1, '{rarh_pkg::MIN_SCALE_RST, rarh_pkg::UNIT_KB, 1'b0}},
		'{'{RATE_MAX, '0}, 1'b1, '{EXP_TOP, rarh_pkg::UNIT_GB, 1'b1}},
		'{'{'0, RATE_MAX}, 1'b1, '{EXP_TOP, rarh_pkg::UNIT_GB, 1'b0}},
		'{'{'0, '0}, 1'b1, '{EXP_TOP, rarh_pkg::UNIT_GB, 1'b0}},
		'{'{'0, '0}, 1'b1, '{EXP_TOP, rarh_pkg::UNIT_GB, 1'b0}},
		'{'{'0, '0}, 1'b1, '{EXP_TOP, rarh_pkg::UNIT_GB, 1'b0}},
		'{'{'0, '0}, 1'b1, '{EXP_TOP, rarh_pkg::UNIT_GB, 1'b0}},
		'{'{'0, '0}, 1'b1, '{EXP_TOP, rarh_pkg::UNIT_GB, 1'b0}},
		'{'{'0, '0}, 1'b1, '{EXP_TOP, rarh_pkg::UNIT_GB, 1'b0}},
		'{'{'0, '0}, 1'b1, '{EXP_TOP, rarh_pkg::UNIT_GB, 1'b0}},
		'{'{'0, '0}, 1'b1, '{EXP_TOP, rarh_pkg::UNIT_GB, 1'b0}},
		'{'{'0, '0}, 1'b1, '{EXP_TOP, rarh_pkg::UNIT_GB, 1'b0}},
		'{'{'0, '0}, 1'b1, '{rarh_pkg::MIN_SCALE_RST, rarh_pkg::UNIT_KB, 1'b1}},
		// from here on the model decides
		'{'{48'h10_0000, '0}, 1'b0, '0},                 // MB range
		'{'{'0, 48'd26214}, 1'b0, '0},                   // target lands just under 2^15
		'{'{48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555}, 1'b0, '0},
		'{'{48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA}, 1'b0, '0},
		'{'{48'h2000_0000, 48'h2000_0000}, 1'b0, '0},    // GB boundary
		'{'{'0, '0}, 1'b0, '0},
		'{'{48'h8000_0000_0000, '0}, 1'b0, '0},
		'{'{48'd1, 48'd1}, 1'b0, '0}
	};

	rate_auto_range_hysteresis_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Scale decision for one sample; advances the model state.
	function automatic rarh_pkg::out_item_t range_step(input rarh_pkg::in_item_t s);
		logic [63:0]                peak;
		logic [63:0]                target;
		logic [63:0]                thr;
		logic [rarh_pkg::EXP_W-1:0] want;
		rarh_pkg::out_item_t        r;
		peak = (s.rx_rate > s.tx_rate) ? 64'(s.rx_rate) : 64'(s.tx_rate);
		target = peak + (peak >> shift_hr);
		want = min_exp;
		while (want < 6'd63 && (64'd1 << want) < target)
			want++;
		// shift past the current exponent means nothing can count as low
		if (32'(low_shift) > 32'(scale_now))
			thr = '0;
		else
			thr = 64'd1 << (scale_now - rarh_pkg::EXP_W'(low_shift));
		r.scale_changed = 1'b0;
		if (want > scale_now) begin
			scale_now = want;
			low_run = '0;
			r.scale_changed = 1'b1;
		end else if (want < scale_now && peak < thr) begin
			low_run = low_run + 1'b1;
			// >= so a shrink length lowered under the running count fires at once
			if (low_run >= shrink_len) begin
				scale_now = want;
				low_run = '0;
				r.scale_changed = 1'b1;
			end
		end else begin
			low_run = '0;
		end
		r.scale_log2 = scale_now;
		r.unit_code = (scale_now >= rarh_pkg::GB_EXP) ? rarh_pkg::UNIT_GB :
		              (scale_now >= rarh_pkg::MB_EXP) ? rarh_pkg::UNIT_MB :
		              rarh_pkg::UNIT_KB;
		return r;
	endfunction

	function automatic logic [rarh_pkg::RATE_BITS-1:0] full_rate();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[rarh_pkg::RATE_BITS-1:0];
	endfunction

	// random rate whose leading one sits at bit lvl-1 (zero for level 0)
	function automatic logic [rarh_pkg::RATE_BITS-1:0] rate_near(input int lvl);
		logic [63:0] r;
		if (lvl == 0)
			return '0;
		r = {$urandom, $urandom} & ((64'd1 << lvl) - 64'd1);
		r[lvl-1] = 1'b1;
		return r[rarh_pkg::RATE_BITS-1:0];
	endfunction

	// Offer one request; returns right after the edge that took it.
	task automatic offer_sample(input rarh_pkg::in_item_t s, input bit pinned,
	                            input rarh_pkg::out_item_t pin);
		rarh_pkg::out_item_t res;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		res = range_step(s);
		pending_ranges.push_back(pinned ? pin : res);
	endtask

	// Stop sending and wait out every outstanding result plus pipe latency.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_ranges.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input rarh_pkg::cfg_reg_t idx, input logic [5:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			rarh_pkg::REG_MIN_SCALE: min_exp = val;
			rarh_pkg::REG_HEADROOM:  shift_hr = val[rarh_pkg::SHIFT_W-1:0];
			rarh_pkg::REG_LOW_SHIFT: low_shift = val[rarh_pkg::SHIFT_W-1:0];
			rarh_pkg::REG_SHRINK:    shrink_len = val[rarh_pkg::CNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Receiver: a long hold-off wins over random stall.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		rarh_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_ranges.size() == 0) begin
				$display("%0t: unexpected result scale %0d unit %0d changed %0d", $time,
				         out_data.scale_log2, out_data.unit_code, out_data.scale_changed);
				errors++;
			end else begin
				want = pending_ranges.pop_front();
				if (out_data.scale_log2 !== want.scale_log2) begin
					$display("%0t: scale_log2 expected %0d got %0d", $time,
					         want.scale_log2, out_data.scale_log2);
					errors++;
				end
				if (out_data.unit_code !== want.unit_code) begin
					$display("%0t: unit_code expected %0d got %0d", $time,
					         want.unit_code, out_data.unit_code);
					errors++;
				end
				if (out_data.scale_changed !== want.scale_changed) begin
					$display("%0t: scale_changed expected %0d got %0d", $time,
					         want.scale_changed, out_data.scale_changed);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		rarh_pkg::in_item_t s;
		reg_set_t           set;
		reg_set_t           fixed_sets [4];
		int                 k;
		int                 run_len;
		int                 kind;
		int                 lvl;
		int                 mode;

		// extremes: all-low, top of the stated ranges, all-ones writes (upper bits
		// masked off, shrink reads as zero), and a shift that outruns small scales
		fixed_sets[0] = '{6'd0, 6'd0, 6'd0, 6'd1};
		fixed_sets[1] = '{6'd40, 6'd8, 6'd8, 6'd15};
		fixed_sets[2] = '{6'h3F, 6'h3F, 6'h3F, 6'h30};
		fixed_sets[3] = '{6'd0, 6'd8, 6'd15, 6'd0};

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = rarh_pkg::REG_MIN_SCALE;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			offer_sample(dir_rows[i].smp, dir_rows[i].pinned, dir_rows[i].res);

		// shrink length lowered below a running low count: next low sample shrinks
		drain();
		write_reg(rarh_pkg::REG_SHRINK, 6'd15);
		repeat (8) offer_sample('0, 1'b0, '0);
		drain();
		write_reg(rarh_pkg::REG_SHRINK, 6'd3);
		repeat (2) offer_sample('0, 1'b0, '0);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			if (ph < 4) begin
				set = fixed_sets[ph];
			end else begin
				set.min_v = ($urandom_range(8) == 0) ? 6'($urandom_range(41, 63))
				                                     : 6'($urandom_range(0, 40));
				set.hr_v  = ($urandom_range(6) == 0) ? 6'($urandom_range(0, 63))
				                                     : 6'($urandom_range(0, 8));
				set.low_v = ($urandom_range(6) == 0) ? 6'($urandom_range(0, 63))
				                                     : 6'($urandom_range(0, 8));
				set.shr_v = ($urandom_range(6) == 0) ? 6'($urandom_range(0, 63))
				                                     : 6'($urandom_range(1, 15));
			end
			write_reg(rarh_pkg::REG_MIN_SCALE, set.min_v);
			write_reg(rarh_pkg::REG_HEADROOM, set.hr_v);
			write_reg(rarh_pkg::REG_LOW_SHIFT, set.low_v);
			write_reg(rarh_pkg::REG_SHRINK, set.shr_v);

			// idling mix rotates: none, sender gaps, receiver stalls, both
			mode = ph % 4;
			send_idle_pct = (mode == 1) ? 48 : (mode == 3) ? 20 : 0;
			stall_pct     = (mode == 2) ? 48 : (mode == 3) ? 20 : 0;

			// Runs of samples at one magnitude: long quiet runs drive the shrink
			// counter, busy runs grow the scale, noise runs break sequences.
			k = 0;
			while (k < PHASE_LEN) begin
				run_len = $urandom_range(1, 20);
				kind = $urandom_range(0, 9);
				lvl = (kind < 5) ? $urandom_range(0, 12)
				                 : $urandom_range(0, rarh_pkg::RATE_BITS);
				for (int j = 0; j < run_len && k < PHASE_LEN; j++) begin
					if (kind < 2) begin
						s.rx_rate = full_rate();
						s.tx_rate = full_rate();
					end else if ($urandom_range(1)) begin
						s.rx_rate = rate_near(lvl);
						s.tx_rate = rate_near($urandom_range(0, lvl));
					end else begin
						s.tx_rate = rate_near(lvl);
						s.rx_rate = rate_near($urandom_range(0, lvl));
					end
					offer_sample(s, 1'b0, '0);
					k++;
					// receiver holds off while requests keep coming: pipe fills, input stalls
					if (ph == 5 && k == 10)
						hold_left = LONG_HOLD;
					// sender pauses mid-phase until everything has come back
					if (ph == 7 && k == 40)
						drain();
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
